/* src/ypsc_pkg.sv */
package ypsc_pkg;

  // fixed point grid
  localparam int ANGLE_FRAC_BITS = 4;
  localparam int GAIN_FRAC_BITS  = 8;

  localparam int CFG_W   = 12;
  localparam int MODE_W  = 3;
  localparam int YAW_W   = 14;
  localparam int SERVO_W = 13;
  localparam int LEVEL_W = 7;
  localparam int ERR_W   = 13;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_STRAIGHT = 3'd0,
    MODE_PREPARE  = 3'd1,
    MODE_TURN1    = 3'd2,
    MODE_TURN2    = 3'd3,
    MODE_CROSS    = 3'd4,
    MODE_STOP     = 3'd5,
    MODE_RECENTER = 3'd6,
    MODE_OTHER    = 3'd7
  } mode_e;

  // register word index, byte address is four times this
  typedef enum logic [2:0] {
    REG_KP_YAW         = 3'd0,
    REG_KD_YAW         = 3'd1,
    REG_KP_TURN        = 3'd2,
    REG_MIN_TURN_RIGHT = 3'd3,
    REG_MIN_TURN_LEFT  = 3'd4,
    REG_CENTER_WINDOW  = 3'd5,
    REG_SERVO_LIMIT    = 3'd6,
    REG_SPARE          = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] kp_yaw;
    logic [CFG_W-1:0] kd_yaw;
    logic [CFG_W-1:0] kp_turn;
    logic [CFG_W-1:0] min_turn_right;
    logic [CFG_W-1:0] min_turn_left;
    logic [CFG_W-1:0] center_window;
    logic [CFG_W-1:0] servo_limit;
  } cfg_t;

  localparam logic [CFG_W-1:0] KP_YAW_RST         = 12'd563;
  localparam logic [CFG_W-1:0] KD_YAW_RST         = 12'd1024;
  localparam logic [CFG_W-1:0] KP_TURN_RST        = 12'd358;
  localparam logic [CFG_W-1:0] MIN_TURN_RIGHT_RST = 12'd672;
  localparam logic [CFG_W-1:0] MIN_TURN_LEFT_RST  = 12'd720;
  localparam logic [CFG_W-1:0] CENTER_WINDOW_RST  = 12'd32;
  localparam logic [CFG_W-1:0] SERVO_LIMIT_RST    = 12'd1280;

  localparam logic [LEVEL_W-1:0] STRAIGHT_THRUST   = 7'd92;
  localparam logic [LEVEL_W-1:0] CROSS_THRUST      = 7'd82;
  localparam logic [LEVEL_W-1:0] RIGHT_TURN_THRUST = 7'd94;
  localparam logic [LEVEL_W-1:0] LEFT_TURN_THRUST  = 7'd98;
  localparam logic [LEVEL_W-1:0] RECENTER_THRUST   = 7'd36;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF         = 7'd0;
  localparam logic [LEVEL_W-1:0] LIFT_ON           = 7'd100;

endpackage

/* src/yaw_pd_steering_controller.sv */
// Yaw steering controller: one servo / thrust / lift command per sensor tick.
// Input channel: in_valid_i with mode_i, turn_left_i, target_yaw_i and
// current_yaw_i; taken at a clock edge where in_valid_i is high and
// in_stall_o is low. Output channel: out_valid_o with servo_angle_o,
// thrust_level_o and lift_level_o; handed over where out_stall_i is low.
// Gains and limits sit behind the APB port, one 32-bit word per register.
// The datapath is three register stages: input register, error wrap and the
// two gain multipliers into a product register, then round, minimum and clamp
// into the output register. One item per cycle is taken while the output
// drains.
// The stored error and last mode are updated as an item leaves the input
// register, so consecutive items chain through them at full rate.
// Reset empties all stages, clears the stored error and mode (straight) and
// loads the register defaults. While the receiver stalls, the output holds
// and the stages behind it fill; in_stall_o rises once all three are full.
module yaw_pd_steering_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ypsc_pkg::MODE_W-1:0]         mode_i,
  input  logic                                turn_left_i,
  input  logic signed [ypsc_pkg::YAW_W-1:0]   target_yaw_i,
  input  logic signed [ypsc_pkg::YAW_W-1:0]   current_yaw_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ypsc_pkg::SERVO_W-1:0] servo_angle_o,
  output logic [ypsc_pkg::LEVEL_W-1:0]        thrust_level_o,
  output logic [ypsc_pkg::LEVEL_W-1:0]        lift_level_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ypsc_pkg::APB_AW-1:0]         paddr,
  input  logic [ypsc_pkg::APB_DW-1:0]         pwdata,
  output logic [ypsc_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import ypsc_pkg::*;

  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
  localparam int DIFF_W    = YAW_W + 1;
  localparam int CAND_W    = YAW_W + 3;
  localparam int WRAP_K    = (2 ** YAW_W) / FULL_TURN + 1;
  localparam int D_W       = ERR_W + 1;
  localparam int PE_W      = CFG_W + 1 + ERR_W;
  localparam int KD_W      = CFG_W + 1 + D_W;
  localparam int ACC_W     = KD_W + 2;
  localparam int RND_W     = ACC_W - GAIN_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (GAIN_FRAC_BITS - 1));

  cfg_t cfg;

  ypsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  function automatic logic is_pd(mode_e m);
    return (m == MODE_STRAIGHT) || (m == MODE_PREPARE) ||
           (m == MODE_CROSS) || (m == MODE_RECENTER);
  endfunction

  function automatic logic is_turn(mode_e m);
    return (m == MODE_TURN1) || (m == MODE_TURN2);
  endfunction

  // pipeline flow
  logic out_ready, adv2, adv1;
  logic v1_q, v2_q, out_valid_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv2       = !v2_q || out_ready;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // input register
  mode_e                     s1_mode_q;
  logic                      s1_left_q;
  logic signed [YAW_W-1:0]   s1_target_q;
  logic signed [YAW_W-1:0]   s1_current_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_mode_q    <= mode_e'(mode_i);
      s1_left_q    <= turn_left_i;
      s1_target_q  <= target_yaw_i;
      s1_current_q <= current_yaw_i;
    end
  end

  // stage 1: wrap error, stored error, products
  logic signed [ERR_W-1:0]  last_error_q;
  mode_e                    last_mode_q;
  logic signed [DIFF_W-1:0] diff;
  logic signed [CAND_W-1:0] cand;
  logic signed [ERR_W-1:0]  err;
  logic                     mode_chg;
  logic signed [ERR_W-1:0]  le_eff;
  logic signed [D_W-1:0]    derr;
  logic [CFG_W-1:0]         gain_sel;
  logic [ERR_W-1:0]         err_mag;
  logic signed [PE_W-1:0]   pe;
  logic signed [KD_W-1:0]   kdd;
  logic                     s1_move;

  always_comb begin
    diff = DIFF_W'(s1_target_q) - DIFF_W'(s1_current_q);
    err  = '0;
    cand = '0;
    // exactly one candidate lands in the half-open turn window
    for (int k = -WRAP_K; k <= WRAP_K; k++) begin
      cand = CAND_W'(diff) - CAND_W'(k * FULL_TURN);
      if (cand >= CAND_W'(-HALF_TURN) && cand < CAND_W'(HALF_TURN)) begin
        err = cand[ERR_W-1:0];
      end
    end
  end

  assign mode_chg = s1_mode_q != last_mode_q;
  assign le_eff   = mode_chg ? '0 : last_error_q;
  assign derr     = D_W'(err) - D_W'(le_eff);
  assign gain_sel = is_turn(s1_mode_q) ? cfg.kp_turn : cfg.kp_yaw;
  assign err_mag  = err[ERR_W-1] ? ERR_W'(-err) : err;
  assign pe       = PE_W'($signed({1'b0, gain_sel})) * PE_W'(err);
  assign kdd      = KD_W'($signed({1'b0, cfg.kd_yaw})) * KD_W'(derr);
  assign s1_move  = v1_q && adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      last_mode_q  <= MODE_STRAIGHT;
    end else if (s1_move) begin
      last_mode_q <= s1_mode_q;
      if (is_pd(s1_mode_q)) begin
        last_error_q <= err;
      end else begin
        last_error_q <= le_eff;
      end
    end
  end

  mode_e                  s2_mode_q;
  logic                   s2_left_q;
  logic signed [PE_W-1:0] s2_pe_q;
  logic signed [KD_W-1:0] s2_kdd_q;
  logic                   s2_dead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_mode_q <= s1_mode_q;
      s2_left_q <= s1_left_q;
      s2_pe_q   <= pe;
      s2_kdd_q  <= kdd;
      s2_dead_q <= err_mag <= ERR_W'(cfg.center_window);
    end
  end

  // stage 2: round, minimum turn magnitude, clamp
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [RND_W-1:0] rnd;
  logic signed [RND_W-1:0] lim;
  logic signed [RND_W-1:0] mn;
  logic signed [RND_W-1:0] p_min;
  logic signed [RND_W-1:0] p_lim;
  logic signed [SERVO_W-1:0] servo_d;
  logic [LEVEL_W-1:0]        thrust_d;
  logic [LEVEL_W-1:0]        lift_d;

  always_comb begin
    if (is_turn(s2_mode_q)) begin
      acc = -ACC_W'(s2_pe_q);
    end else begin
      acc = -(ACC_W'(s2_pe_q) + ACC_W'(s2_kdd_q));
    end
    acc_r = acc + RND_HALF;
    rnd   = acc_r[ACC_W-1:GAIN_FRAC_BITS];
    lim   = $signed({{(RND_W-CFG_W){1'b0}}, cfg.servo_limit});
    mn    = $signed({{(RND_W-CFG_W){1'b0}},
                     s2_left_q ? cfg.min_turn_left : cfg.min_turn_right});
    p_min = rnd;
    if (is_turn(s2_mode_q)) begin
      if (rnd > 0 && rnd < mn) begin
        p_min = mn;
      end else if (rnd < 0 && rnd > -mn) begin
        p_min = -mn;
      end
    end
    if (p_min > lim) begin
      p_lim = lim;
    end else if (p_min < -lim) begin
      p_lim = -lim;
    end else begin
      p_lim = p_min;
    end

    servo_d  = p_lim[SERVO_W-1:0];
    thrust_d = LEVEL_OFF;
    lift_d   = LIFT_ON;
    case (s2_mode_q) inside
      MODE_STRAIGHT: thrust_d = STRAIGHT_THRUST;
      MODE_PREPARE:  lift_d   = LEVEL_OFF;
      MODE_CROSS:    thrust_d = CROSS_THRUST;
      MODE_RECENTER: thrust_d = RECENTER_THRUST;
      MODE_TURN1, MODE_TURN2: begin
        thrust_d = s2_left_q ? LEFT_TURN_THRUST : RIGHT_TURN_THRUST;
        if (s2_dead_q) begin
          servo_d = '0;
        end
      end
      default: begin
        servo_d = '0;
        lift_d  = LEVEL_OFF;
      end
    endcase
  end

  // output register
  logic signed [SERVO_W-1:0] servo_q;
  logic [LEVEL_W-1:0]        thrust_q;
  logic [LEVEL_W-1:0]        lift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && v2_q) begin
      servo_q  <= servo_d;
      thrust_q <= thrust_d;
      lift_q   <= lift_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign servo_angle_o  = servo_q;
  assign thrust_level_o = thrust_q;
  assign lift_level_o   = lift_q;

  // servo never leaves the configured limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (SERVO_W + 1)'(servo_angle_o) <= $signed({2'b00, cfg.servo_limit}) &&
                    (SERVO_W + 1)'(servo_angle_o) >= -$signed({2'b00, cfg.servo_limit}))
    else $error("servo beyond limit");

  // a mode change into a non-pd mode leaves a cleared error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && mode_chg && !is_pd(s1_mode_q) |=> last_error_q == '0)
    else $error("stored error not cleared on mode change");

  // a new result only appears when stage 2 held an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(v2_q))
    else $error("result without item");

endmodule

/* src/ypsc_regs.sv */
module ypsc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ypsc_pkg::APB_AW-1:0] paddr,
  input  logic [ypsc_pkg::APB_DW-1:0] pwdata,
  output logic [ypsc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output ypsc_pkg::cfg_t              cfg_o
);
  import ypsc_pkg::*;

  cfg_t             cfg_q;
  logic             wr_en;
  reg_idx_e         idx;
  logic [CFG_W-1:0] wdata;
  logic [CFG_W-1:0] rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wdata  = pwdata[CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_yaw         <= KP_YAW_RST;
      cfg_q.kd_yaw         <= KD_YAW_RST;
      cfg_q.kp_turn        <= KP_TURN_RST;
      cfg_q.min_turn_right <= MIN_TURN_RIGHT_RST;
      cfg_q.min_turn_left  <= MIN_TURN_LEFT_RST;
      cfg_q.center_window  <= CENTER_WINDOW_RST;
      cfg_q.servo_limit    <= SERVO_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_KP_YAW:         cfg_q.kp_yaw         <= wdata;
        REG_KD_YAW:         cfg_q.kd_yaw         <= wdata;
        REG_KP_TURN:        cfg_q.kp_turn        <= wdata;
        REG_MIN_TURN_RIGHT: cfg_q.min_turn_right <= wdata;
        REG_MIN_TURN_LEFT:  cfg_q.min_turn_left  <= wdata;
        REG_CENTER_WINDOW:  cfg_q.center_window  <= wdata;
        REG_SERVO_LIMIT:    cfg_q.servo_limit    <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP_YAW:         rdata = cfg_q.kp_yaw;
      REG_KD_YAW:         rdata = cfg_q.kd_yaw;
      REG_KP_TURN:        rdata = cfg_q.kp_turn;
      REG_MIN_TURN_RIGHT: rdata = cfg_q.min_turn_right;
      REG_MIN_TURN_LEFT:  rdata = cfg_q.min_turn_left;
      REG_CENTER_WINDOW:  rdata = cfg_q.center_window;
      REG_SERVO_LIMIT:    rdata = cfg_q.servo_limit;
      default:            rdata = '0;
    endcase
  end

  assign prdata = {{(APB_DW-CFG_W){1'b0}}, rdata};
  assign cfg_o  = cfg_q;

endmodule

/* dv/testbench.sv */
module testbench;
  import ypsc_pkg::*;

  typedef struct packed {
    logic signed [SERVO_W-1:0] servo;
    logic [LEVEL_W-1:0]        thrust;
    logic [LEVEL_W-1:0]        lift;
  } steer_cmd_t;

  class steer_scoreboard;
    localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
    localparam longint ROUND_HALF = longint'(1) << (GAIN_FRAC_BITS - 1);

    logic [CFG_W-1:0] kp_yaw, kd_yaw, kp_turn;
    logic [CFG_W-1:0] min_right, min_left, window, servo_limit;
    logic signed [ERR_W-1:0] last_err;
    mode_e last_mode;
    steer_cmd_t expected_cmds[$];
    int errors;

    function new();
      kp_yaw      = KP_YAW_RST;
      kd_yaw      = KD_YAW_RST;
      kp_turn     = KP_TURN_RST;
      min_right   = MIN_TURN_RIGHT_RST;
      min_left    = MIN_TURN_LEFT_RST;
      window      = CENTER_WINDOW_RST;
      servo_limit = SERVO_LIMIT_RST;
      last_err    = '0;
      last_mode   = MODE_STRAIGHT;
      errors      = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [APB_DW-1:0] data);
      case (idx)
        REG_KP_YAW:         kp_yaw = data[CFG_W-1:0];
        REG_KD_YAW:         kd_yaw = data[CFG_W-1:0];
        REG_KP_TURN:        kp_turn = data[CFG_W-1:0];
        REG_MIN_TURN_RIGHT: min_right = data[CFG_W-1:0];
        REG_MIN_TURN_LEFT:  min_left = data[CFG_W-1:0];
        REG_CENTER_WINDOW:  window = data[CFG_W-1:0];
        REG_SERVO_LIMIT:    servo_limit = data[CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint saturate_cmd(longint v);
      longint lim;
      lim = longint'(servo_limit);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void note_item(mode_e m, bit left, logic signed [YAW_W-1:0] tgt,
                            logic signed [YAW_W-1:0] cur);
      int err, mag, mn;
      longint acc, p;
      steer_cmd_t cmd;
      // heading difference folded into one turn around zero
      err = (int'(tgt) - int'(cur) + HALF_TURN) % FULL_TURN;
      if (err < 0) err += FULL_TURN;
      err -= HALF_TURN;
      if (m != last_mode) begin
        last_err  = '0;
        last_mode = m;
      end
      cmd.servo  = '0;
      cmd.thrust = LEVEL_OFF;
      cmd.lift   = LIFT_ON;
      case (m)
        MODE_STRAIGHT, MODE_PREPARE, MODE_CROSS, MODE_RECENTER: begin
          acc = -(longint'(kp_yaw) * err + longint'(kd_yaw) * (err - int'(last_err)));
          last_err = err[ERR_W-1:0];
          p = saturate_cmd((acc + ROUND_HALF) >>> GAIN_FRAC_BITS);
          cmd.servo = p[SERVO_W-1:0];
          case (m)
            MODE_STRAIGHT: cmd.thrust = STRAIGHT_THRUST;
            MODE_CROSS:    cmd.thrust = CROSS_THRUST;
            MODE_RECENTER: cmd.thrust = RECENTER_THRUST;
            default: begin
              cmd.thrust = LEVEL_OFF;
              cmd.lift   = LEVEL_OFF;
            end
          endcase
        end
        MODE_TURN1, MODE_TURN2: begin
          mag = (err < 0) ? -err : err;
          cmd.thrust = left ? LEFT_TURN_THRUST : RIGHT_TURN_THRUST;
          if (mag > int'(window)) begin
            p = (-(longint'(kp_turn) * err) + ROUND_HALF) >>> GAIN_FRAC_BITS;
            mn = left ? int'(min_left) : int'(min_right);
            // a zero command stays centered, no minimum kick
            if (p > 0 && p < mn) p = mn;
            else if (p < 0 && p > -mn) p = -mn;
            p = saturate_cmd(p);
            cmd.servo = p[SERVO_W-1:0];
          end
        end
        default: begin
          cmd.thrust = LEVEL_OFF;
          cmd.lift   = LEVEL_OFF;
        end
      endcase
      expected_cmds.push_back(cmd);
    endfunction

    function void check_cmd(steer_cmd_t got);
      steer_cmd_t want;
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t unexpected item: expected none, actual servo %0d thrust %0d lift %0d",
                 $time, got.servo, got.thrust, got.lift);
        return;
      end
      want = expected_cmds.pop_front();
      if (got.servo !== want.servo) begin
        errors++;
        $display("%0t servo_angle: expected %0d, actual %0d", $time, want.servo, got.servo);
      end
      if (got.thrust !== want.thrust) begin
        errors++;
        $display("%0t thrust_level: expected %0d, actual %0d", $time, want.thrust, got.thrust);
      end
      if (got.lift !== want.lift) begin
        errors++;
        $display("%0t lift_level: expected %0d, actual %0d", $time, want.lift, got.lift);
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [MODE_W-1:0]         mode_i;
  logic                      turn_left_i;
  logic signed [YAW_W-1:0]   target_yaw_i;
  logic signed [YAW_W-1:0]   current_yaw_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [SERVO_W-1:0] servo_angle_o;
  logic [LEVEL_W-1:0]        thrust_level_o;
  logic [LEVEL_W-1:0]        lift_level_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  steer_scoreboard sb;
  int  send_idle_max;
  int  recv_idle_max;
  bit  hold_req;

  yaw_pd_steering_controller uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL yaw_pd_steering_controller");
    $finish;
  end

  task automatic write_reg(reg_idx_e idx, int value);
    logic [APB_DW-1:0] data;
    // junk in the upper bits must be dropped by the register
    data = ($urandom() & 32'hFFFF_F000) | (value & 32'h0000_0FFF);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * idx);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic load_gains(int kp, int kd, int kpt, int min_r, int min_l, int win, int lim);
    write_reg(REG_KP_YAW, kp);
    write_reg(REG_KD_YAW, kd);
    write_reg(REG_KP_TURN, kpt);
    write_reg(REG_MIN_TURN_RIGHT, min_r);
    write_reg(REG_MIN_TURN_LEFT, min_l);
    write_reg(REG_CENTER_WINDOW, win);
    write_reg(REG_SERVO_LIMIT, lim);
    write_reg(REG_SPARE, $urandom());
  endtask

  task automatic send_item(mode_e m, bit left, int tgt, int cur);
    int gap;
    logic signed [YAW_W-1:0] t, c;
    t = tgt[YAW_W-1:0];
    c = cur[YAW_W-1:0];
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    turn_left_i   <= left;
    target_yaw_i  <= t;
    current_yaw_i <= c;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_item(m, left, t, c);
  endtask

  task automatic send_directed_items();
    send_item(MODE_STRAIGHT, 1'b0, 0, 0);
    send_item(MODE_STRAIGHT, 1'b0, 160, 0);
    send_item(MODE_STRAIGHT, 1'b1, 160, 150);
    send_item(MODE_STRAIGHT, 1'b0, 2879, 0);
    send_item(MODE_STRAIGHT, 1'b0, 2880, 0);
    send_item(MODE_STRAIGHT, 1'b0, -2880, 0);
    send_item(MODE_PREPARE, 1'b0, 5760, -5760);
    send_item(MODE_PREPARE, 1'b0, 100, 0);
    send_item(MODE_PREPARE, 1'b0, 100, 90);
    send_item(MODE_CROSS, 1'b0, -8192, 8191);
    send_item(MODE_CROSS, 1'b1, -5760, 5760);
    send_item(MODE_RECENTER, 1'b0, 8191, -8192);
    // deadband edges, then the minimum kick in both directions
    send_item(MODE_TURN1, 1'b1, 32, 0);
    send_item(MODE_TURN1, 1'b1, 33, 0);
    send_item(MODE_TURN1, 1'b0, -33, 0);
    send_item(MODE_TURN2, 1'b0, 2000, 0);
    send_item(MODE_TURN2, 1'b1, -32, 0);
    send_item(MODE_TURN2, 1'b1, -2000, 0);
    send_item(MODE_TURN1, 1'b1, 8191, -8192);
    send_item(MODE_STOP, 1'b0, 1000, 0);
    send_item(MODE_STRAIGHT, 1'b0, 200, 0);
    send_item(MODE_OTHER, 1'b1, -1000, 500);
    send_item(MODE_STRAIGHT, 1'b0, 200, 0);
  endtask

  task automatic send_random_items(int n);
    mode_e run_mode, m;
    int run_left, sel, tgt, cur;
    run_left = 0;
    run_mode = MODE_STRAIGHT;
    repeat (n) begin
      if (run_left == 0) begin
        run_mode = mode_e'($urandom_range(0, 7));
        run_left = $urandom_range(1, 20);
      end
      run_left--;
      m = run_mode;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // any bit pattern on both headings
        tgt = $urandom();
        cur = $urandom();
      end else if (sel < 25) begin
        tgt = $urandom_range(0, 11520) - 5760;
        cur = $urandom_range(0, 11520) - 5760;
      end else begin
        tgt = $urandom_range(0, 11520) - 5760;
        cur = tgt + $urandom_range(0, 1200) - 600;
      end
      // a stray mode breaks the run now and then
      if ($urandom_range(0, 99) < 8) m = mode_e'($urandom_range(0, 7));
      send_item(m, 1'($urandom_range(0, 1)), tgt, cur);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        n = 80;
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, recv_idle_max);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_cmd('{servo: servo_angle_o, thrust: thrust_level_o, lift: lift_level_o});
    end
  end

  initial begin
    in_valid_i    = 1'b0;
    mode_i        = '0;
    turn_left_i   = 1'b0;
    target_yaw_i  = '0;
    current_yaw_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    send_idle_max = 10;
    recv_idle_max = 10;
    sb = new();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults
    send_directed_items();
    send_random_items(250);
    drain();

    load_gains(0, 0, 0, 0, 0, 0, 0);
    send_random_items(100);
    drain();

    // top of the gain ranges, zero window, no idling on either side
    send_idle_max = 0;
    recv_idle_max = 0;
    load_gains(4095, 4095, 4095, 2880, 2880, 0, 2880);
    send_random_items(120);
    drain();

    // minimum above the limit; tiny turn gain rounds small errors to zero
    send_idle_max = 10;
    recv_idle_max = 10;
    load_gains(300, 900, 1, 2880, 2000, 16, 500);
    send_random_items(120);
    drain();

    // back to back items against a long receiver hold-off
    send_idle_max = 0;
    load_gains(563, 1024, 358, 672, 720, 32, 1280);
    hold_req = 1'b1;
    send_random_items(150);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_max = (ph == 1) ? 0 : 10;
      recv_idle_max = (ph == 1) ? 0 : 10;
      load_gains($urandom_range(0, 1024), $urandom_range(0, 1024), $urandom_range(0, 1024),
                 $urandom_range(0, 2880), $urandom_range(0, 2880), $urandom_range(0, 300),
                 (ph == 3) ? 4095 : $urandom_range(0, 2880));
      send_random_items(115);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
      $display("PASS yaw_pd_steering_controller");
    end else begin
      $display("FAIL yaw_pd_steering_controller");
    end
    $finish;
  end
endmodule
